// ----- rtl/pose_graph_relative_pose_residual_core_assert.svh -----
// assertion macros for the relative pose residual core
// expects i_clk and i_rst_n in the module that uses them
`ifndef POSE_GRAPH_RELATIVE_POSE_RESIDUAL_CORE_ASSERT_SVH
`define POSE_GRAPH_RELATIVE_POSE_RESIDUAL_CORE_ASSERT_SVH

// same-cycle implication
`define PGR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PGR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pgrpr_pkg.sv -----
// types, constants and helpers for the relative pose residual core
// no dependencies
package pgrpr_pkg;

    localparam int NRES  = 6;
    localparam int NLANE = 3;
    localparam int NQ    = 4;
    localparam int VW    = 21;
    localparam int QW    = 16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    // cyclic neighbours of a vector lane, used by the cross products
    localparam int NXT [NLANE] = '{1, 2, 0};
    localparam int PRV [NLANE] = '{2, 0, 1};

    localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
    localparam logic signed [67:0] SAT_LO = -68'sd2147483648;

    typedef struct packed {
        logic               command;
        logic [5:0]         weight_index;
        logic signed [31:0] weight_value;
        logic [62:0]        source_position;
        logic [63:0]        source_rotation;
        logic [62:0]        target_position;
        logic [63:0]        target_rotation;
        logic [62:0]        measured_translation;
        logic [63:0]        measured_rotation;
    } t_in;

    typedef struct packed {
        logic signed [31:0] res_trans_x;
        logic signed [31:0] res_trans_y;
        logic signed [31:0] res_trans_z;
        logic signed [31:0] res_rot_x;
        logic signed [31:0] res_rot_y;
        logic signed [31:0] res_rot_z;
    } t_out;

    // weight load request carried alongside each item
    typedef struct packed {
        logic               command;
        logic [5:0]         weight_index;
        logic signed [31:0] weight_value;
    } t_wctl;

    typedef struct packed {
        t_wctl                  ctl;
        logic [NRES-1:0][31:0]  res;
    } t_res;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = $signed(v[31:0]);
        end
        return r;
    endfunction

endpackage

// ----- rtl/pgrpr_geom.sv -----
// four-stage pipeline forming the six unweighted residuals of one edge
// depends on pgrpr_pkg
module pgrpr_geom (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  pgrpr_pkg::t_in    i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output pgrpr_pkg::t_res   o_res
);
    import pgrpr_pkg::*;

    logic rdy1, rdy2, rdy3, rdy4;
    logic r_v1, r_v2, r_v3, r_v4;

    // stage 1: unpack, position difference, estimated rotation
    logic signed [VW-1:0] ps [NLANE];
    logic signed [VW-1:0] pt [NLANE];
    logic signed [VW-1:0] pm [NLANE];
    logic signed [QW-1:0] qs [NQ];
    logic signed [QW-1:0] qt [NQ];
    logic signed [QW-1:0] qm [NQ];
    logic signed [21:0]   n_d1 [NLANE];
    logic signed [33:0]   n_est1 [NQ];

    t_wctl                r_ctl1;
    logic signed [21:0]   r_d1 [NLANE];
    logic signed [VW-1:0] r_pm1 [NLANE];
    logic signed [QW-1:0] r_qs1 [NQ];
    logic signed [QW-1:0] r_qm1 [NQ];
    logic signed [33:0]   r_est1 [NQ];

    always_comb begin
        for (int k = 0; k < NLANE; k++) begin
            ps[k]   = $signed(i_req.source_position[VW*k +: VW]);
            pt[k]   = $signed(i_req.target_position[VW*k +: VW]);
            pm[k]   = $signed(i_req.measured_translation[VW*k +: VW]);
            n_d1[k] = 22'(pt[k]) - 22'(ps[k]);
        end
        for (int k = 0; k < NQ; k++) begin
            qs[k] = $signed(i_req.source_rotation[QW*k +: QW]);
            qt[k] = $signed(i_req.target_rotation[QW*k +: QW]);
            qm[k] = $signed(i_req.measured_rotation[QW*k +: QW]);
        end
        // target times conjugate of source
        n_est1[0] = 34'(qt[0]) * 34'(qs[0]) + 34'(qt[1]) * 34'(qs[1])
                  + 34'(qt[2]) * 34'(qs[2]) + 34'(qt[3]) * 34'(qs[3]);
        n_est1[1] = 34'(qt[1]) * 34'(qs[0]) - 34'(qt[0]) * 34'(qs[1])
                  - 34'(qt[2]) * 34'(qs[3]) + 34'(qt[3]) * 34'(qs[2]);
        n_est1[2] = 34'(qt[2]) * 34'(qs[0]) - 34'(qt[0]) * 34'(qs[2])
                  + 34'(qt[1]) * 34'(qs[3]) - 34'(qt[3]) * 34'(qs[1]);
        n_est1[3] = 34'(qt[3]) * 34'(qs[0]) - 34'(qt[0]) * 34'(qs[3])
                  - 34'(qt[1]) * 34'(qs[2]) + 34'(qt[2]) * 34'(qs[1]);
    end

    // stage 2: t = 2 (u x d), delta rotation
    logic signed [39:0] n_t2 [NLANE];
    logic signed [51:0] n_dq2 [NLANE];

    t_wctl                r_ctl2;
    logic signed [21:0]   r_d2 [NLANE];
    logic signed [VW-1:0] r_pm2 [NLANE];
    logic signed [QW-1:0] r_qs2 [NQ];
    logic signed [39:0]   r_t2 [NLANE];
    logic signed [51:0]   r_dq2 [NLANE];

    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            n_t2[i] = (40'(r_qs1[NXT[i]+1]) * 40'(r_d1[PRV[i]])
                     - 40'(r_qs1[PRV[i]+1]) * 40'(r_d1[NXT[i]])) <<< 1;
        end
        // measured times conjugate of estimate, vector part only
        n_dq2[0] = 52'(r_qm1[1]) * 52'(r_est1[0]) - 52'(r_qm1[0]) * 52'(r_est1[1])
                 - 52'(r_qm1[2]) * 52'(r_est1[3]) + 52'(r_qm1[3]) * 52'(r_est1[2]);
        n_dq2[1] = 52'(r_qm1[2]) * 52'(r_est1[0]) - 52'(r_qm1[0]) * 52'(r_est1[2])
                 + 52'(r_qm1[1]) * 52'(r_est1[3]) - 52'(r_qm1[3]) * 52'(r_est1[1]);
        n_dq2[2] = 52'(r_qm1[3]) * 52'(r_est1[0]) - 52'(r_qm1[0]) * 52'(r_est1[3])
                 - 52'(r_qm1[1]) * 52'(r_est1[2]) + 52'(r_qm1[2]) * 52'(r_est1[1]);
    end

    // stage 3: rotation products, rounding of the rotation residual
    logic signed [55:0] n_m0 [NLANE];
    logic signed [55:0] n_ma [NLANE];
    logic signed [55:0] n_mb [NLANE];
    logic signed [52:0] dq_rnd [NLANE];
    logic signed [31:0] n_rr3 [NLANE];

    t_wctl                r_ctl3;
    logic signed [21:0]   r_d3 [NLANE];
    logic signed [VW-1:0] r_pm3 [NLANE];
    logic signed [55:0]   r_m0 [NLANE];
    logic signed [55:0]   r_ma [NLANE];
    logic signed [55:0]   r_mb [NLANE];
    logic signed [31:0]   r_rr3 [NLANE];

    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            n_m0[i]   = 56'(r_qs2[0]) * 56'(r_t2[i]);
            n_ma[i]   = 56'(r_qs2[NXT[i]+1]) * 56'(r_t2[PRV[i]]);
            n_mb[i]   = 56'(r_qs2[PRV[i]+1]) * 56'(r_t2[NXT[i]]);
            dq_rnd[i] = 53'(r_dq2[i]) + (53'sd1 <<< 24);
            n_rr3[i]  = sat32(68'(dq_rnd[i] >>> 25));
        end
    end

    // stage 4: sum the rotated vector, round, subtract measurement
    logic signed [59:0] rot [NLANE];
    logic signed [59:0] rot_rnd [NLANE];
    logic signed [67:0] rt [NLANE];
    t_res               n_res4;
    t_res               r_res4;

    always_comb begin
        n_res4.ctl = r_ctl3;
        for (int i = 0; i < NLANE; i++) begin
            rot[i] = (60'(r_d3[i]) <<< 28) + 60'(r_m0[i]) + 60'(r_ma[i])
                   - 60'(r_mb[i]);
            rot_rnd[i] = (rot[i] + (60'sd1 <<< 21)) >>> 22;
            rt[i] = 68'(rot_rnd[i]) - (68'(r_pm3[i]) <<< 6);
            n_res4.res[i]         = sat32(rt[i]);
            n_res4.res[NLANE + i] = r_rr3[i];
        end
    end

    assign rdy4    = !r_v4 || !i_stall;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;
    assign o_valid = r_v4;
    assign o_res   = r_res4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_ctl1.command      <= i_req.command;
            r_ctl1.weight_index <= i_req.weight_index;
            r_ctl1.weight_value <= i_req.weight_value;
            r_d1   <= n_d1;
            r_pm1  <= pm;
            r_qs1  <= qs;
            r_qm1  <= qm;
            r_est1 <= n_est1;
        end
        if (rdy2) begin
            r_ctl2 <= r_ctl1;
            r_d2   <= r_d1;
            r_pm2  <= r_pm1;
            r_qs2  <= r_qs1;
            r_t2   <= n_t2;
            r_dq2  <= n_dq2;
        end
        if (rdy3) begin
            r_ctl3 <= r_ctl2;
            r_d3   <= r_d2;
            r_pm3  <= r_pm2;
            r_m0   <= n_m0;
            r_ma   <= n_ma;
            r_mb   <= n_mb;
            r_rr3  <= n_rr3;
        end
        if (rdy4) begin
            r_res4 <= n_res4;
        end
    end

endmodule

// ----- rtl/pgrpr_wsum.sv -----
// weight matrix store and two-stage weighting of the residual vector
// depends on pgrpr_pkg and the assertion macro header
`include "pose_graph_relative_pose_residual_core_assert.svh"

module pgrpr_wsum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  pgrpr_pkg::t_res   i_res,
    output logic              o_valid,
    input  logic              i_stall,
    output pgrpr_pkg::t_out   o_out
);
    import pgrpr_pkg::*;

    logic rdy5, rdy6, wr_en;
    logic r_v5, r_v6;

    logic signed [31:0] r_w  [NRES][NRES];
    logic signed [63:0] r_p5 [NRES][NRES];
    logic signed [66:0] acc  [NRES];
    logic signed [66:0] acc_rnd [NRES];
    logic signed [31:0] n_out [NRES];
    logic signed [31:0] r_out [NRES];

    assign rdy6    = !r_v6 || !i_stall;
    assign rdy5    = !r_v5 || rdy6;
    assign o_stall = !rdy5;
    assign o_valid = r_v6;

    // a load takes effect as it passes the point where weights are read,
    // so earlier requests still see the old matrix
    assign wr_en = i_valid && rdy5 && (i_res.ctl.command == CMD_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NRES; r++) begin
                for (int c = 0; c < NRES; c++) begin
                    r_w[r][c] <= (r == c) ? ONE_Q16 : 32'sd0;
                end
            end
        end else if (wr_en) begin
            for (int r = 0; r < NRES; r++) begin
                for (int c = 0; c < NRES; c++) begin
                    if (i_res.ctl.weight_index == 6'(r * NRES + c)) begin
                        r_w[r][c] <= i_res.ctl.weight_value;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < NRES; r++) begin
            acc[r] = '0;
            for (int c = 0; c < NRES; c++) begin
                acc[r] = acc[r] + 67'(r_p5[r][c]);
            end
            acc_rnd[r] = (acc[r] + 67'sd32768) >>> 16;
            n_out[r]   = sat32(68'(acc_rnd[r]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (rdy5) r_v5 <= i_valid && (i_res.ctl.command == CMD_EVAL);
            if (rdy6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            for (int r = 0; r < NRES; r++) begin
                for (int c = 0; c < NRES; c++) begin
                    r_p5[r][c] <= 64'(r_w[r][c]) * 64'($signed(i_res.res[c]));
                end
            end
        end
        if (rdy6) begin
            r_out <= n_out;
        end
    end

    assign o_out.res_trans_x = r_out[0];
    assign o_out.res_trans_y = r_out[1];
    assign o_out.res_trans_z = r_out[2];
    assign o_out.res_rot_x   = r_out[3];
    assign o_out.res_rot_y   = r_out[4];
    assign o_out.res_rot_z   = r_out[5];

    `PGR_ASSERT_NXT(a_load_no_result, wr_en, !r_v5, "weight load produced a result")
    `PGR_ASSERT_NXT(a_load_first, wr_en && (i_res.ctl.weight_index == 6'd0),
        r_w[0][0] == $past(i_res.ctl.weight_value), "weight entry not written")
    `PGR_ASSERT_NXT(a_stage_move, r_v5 && rdy6, r_v6, "weighted request lost")
    `PGR_ASSERT_IMP(a_no_write_when_full, wr_en, rdy5, "weight write while stage 5 blocked")

endmodule

// ----- rtl/pose_graph_relative_pose_residual_core.sv -----
// a request's result passes stages 1 to 4 in pgrpr_geom, then stages 5 and 6 in pgrpr_wsum, before it is offered
// throughput: one request per cycle while the output is not stalled; six pipeline stages, none iterating
// weight loads produce no result and update the matrix in request order
// reset: synchronous, active low; empties the pipeline, weights become identity
// top level of the relative pose residual core, depends on pgrpr_pkg,
// pgrpr_geom and pgrpr_wsum
module pose_graph_relative_pose_residual_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pgrpr_pkg::t_in    i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pgrpr_pkg::t_out   o_out
);
    import pgrpr_pkg::*;

    logic res_valid;
    logic res_stall;
    t_res res;

    pgrpr_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_req   (i_in),
        .o_valid (res_valid),
        .i_stall (res_stall),
        .o_res   (res)
    );

    pgrpr_wsum u_wsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_stall (res_stall),
        .i_res   (res),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_out   (o_out)
    );

endmodule
